/* design/fbw_pkg.sv */
// Shared types, codes and helper functions for the framebuffer window writer.
package fbw_pkg;

  // Transaction kinds on the command port
  typedef enum logic [2:0] {
    KIND_SET_WINDOW   = 3'd0,
    KIND_WRITE_PIXEL  = 3'd1,
    KIND_WRITE_PACKED = 3'd2,
    KIND_SET_PIXEL_AT = 3'd3,
    KIND_LOAD_PALETTE = 3'd4,
    KIND_READ_PIXEL   = 3'd5
  } kind_t;

  // Configuration register indexes
  localparam logic CFG_SURFACE_WIDTH  = 1'b0;
  localparam logic CFG_SURFACE_HEIGHT = 1'b1;

  localparam int CFG_W = 9;
  localparam logic [CFG_W-1:0] CFG_RESET_SIZE = 9'd256;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
  } cursor_t;

  typedef struct packed {
    logic [7:0] left;
    logic [7:0] top;
    logic [7:0] right;
    logic [7:0] bottom;
  } window_t;

  // Index mask for a packed width; zero for an unsupported width
  function automatic logic [7:0] fbw_index_mask(input logic [3:0] bits);
    logic [7:0] m;
    case (bits)
      4'd1:    m = 8'h01;
      4'd2:    m = 8'h03;
      4'd4:    m = 8'h0F;
      4'd8:    m = 8'hFF;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // Indices per byte for a packed width; zero for an unsupported width
  function automatic logic [3:0] fbw_per_byte(input logic [3:0] bits);
    logic [3:0] n;
    case (bits)
      4'd1:    n = 4'd8;
      4'd2:    n = 4'd4;
      4'd4:    n = 4'd2;
      4'd8:    n = 4'd1;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  // Raster step inside the window; compares in 9 bits so 255+1 wraps
  function automatic cursor_t fbw_cursor_step(input cursor_t c, input window_t w);
    logic [8:0] nx;
    logic [8:0] ny;
    cursor_t r;
    nx = {1'b0, c.x} + 9'd1;
    ny = {1'b0, c.y};
    if (nx > {1'b0, w.right}) begin
      nx = {1'b0, w.left};
      ny = ny + 9'd1;
    end
    if (ny > {1'b0, w.bottom}) begin
      ny = {1'b0, w.top};
    end
    r.x = nx[7:0];
    r.y = ny[7:0];
    return r;
  endfunction

endpackage

/* design/fbw_frame_ram.sv */
// Frame store: one write port and one registered read port.
module fbw_frame_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/fbw_palette_ram.sv */
// Palette store: one write port and one registered read port.
module fbw_palette_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/fbw_addr_gen.sv */
// Surface bounds check and row-major address for one pixel position.
module fbw_addr_gen import fbw_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int AW         = 16
) (
  input  logic [CFG_W-1:0] surface_width,
  input  logic [CFG_W-1:0] surface_height,
  input  logic [7:0]       x,
  input  logic [7:0]       y,
  output logic             in_bounds,
  output logic [AW-1:0]    addr
);

  // Sum width: 8 x 9 bit product plus column, or the address width if larger
  localparam int SW = (AW > 17) ? AW : 17;

  logic [CFG_W-1:0] eff_width;
  logic [CFG_W-1:0] eff_height;
  logic [SW-1:0]    full_addr;

  // Register values above the store size saturate to it
  assign eff_width  = (32'(surface_width) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : surface_width;
  assign eff_height = (32'(surface_height) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT)
                                                         : surface_height;

  assign in_bounds = ({1'b0, x} < eff_width) && ({1'b0, y} < eff_height);

  // Row stride follows the effective width
  assign full_addr = SW'(y) * SW'(eff_width) + SW'(x);
  assign addr      = full_addr[AW-1:0];

endmodule

/* design/framebuffer_window_pixel_writer.sv */
// Top level: command sequencer around the frame store and palette store.
//
// RGB565 framebuffer with an address window. After reset the frame store is
// cleared one entry per cycle with busy high; configuration writes are taken
// during that pass. A command is taken when start is high and busy is low.
// set_window, write_pixel, set_pixel_at and load_palette finish in the accept
// cycle and busy stays low. read_pixel holds busy in a read state while the
// frame store read completes; read_data then shows for exactly one cycle with
// read_valid, and the receiver cannot stall it. write_packed reads the first
// palette entry in the accept cycle, then writes one frame store entry per
// cycle, the next palette read overlapping the current write. Kinds 6 and 7
// do nothing.
module framebuffer_window_pixel_writer import fbw_pkg::*; #(
  parameter int MAX_WIDTH     = 256,
  parameter int MAX_HEIGHT    = 256,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       kind,
  input  logic [7:0]       win_left,
  input  logic [7:0]       win_top,
  input  logic [7:0]       win_right,
  input  logic [7:0]       win_bottom,
  input  logic [7:0]       pos_x,
  input  logic [7:0]       pos_y,
  input  logic [15:0]      pixel_value,
  input  logic [7:0]       packed_byte,
  input  logic [3:0]       index_bits,
  input  logic [3:0]       valid_pixels,
  input  logic [7:0]       palette_index,
  output logic [15:0]      read_data,
  output logic             read_valid,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW          = $clog2(FRAME_DEPTH);
  localparam int PW          = $clog2(PALETTE_DEPTH);
  localparam logic [AW-1:0] CLEAR_LAST = AW'(FRAME_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PACK
  } state_t;

  state_t           state;
  logic [AW-1:0]    clear_cnt;
  logic [CFG_W-1:0] surface_width;
  logic [CFG_W-1:0] surface_height;
  window_t          window;
  cursor_t          cursor;
  logic             rd_inside;
  logic [7:0]       pk_shift;
  logic [7:0]       pk_mask;
  logic [3:0]       pk_bits;
  logic [3:0]       pk_left;
  logic             pal_zero;

  kind_t            cmd;
  logic             accept;
  logic             use_pos;
  logic [7:0]       ag_x;
  logic [7:0]       ag_y;
  logic             ag_inside;
  logic [AW-1:0]    ag_addr;
  cursor_t          cursor_next;
  logic [3:0]       per_byte;
  logic [3:0]       count_sat;
  logic [7:0]       pal_idx;
  logic             pal_in_range;
  logic [PW-1:0]    pal_raddr;
  logic             pal_we;
  logic [15:0]      pal_q;
  logic [15:0]      colour;
  logic             fr_we;
  logic [AW-1:0]    fr_waddr;
  logic [15:0]      fr_wdata;
  logic [15:0]      fr_q;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign cmd    = kind_t'(kind);

  // Position source: given position for direct access, cursor otherwise
  assign use_pos = (state == ST_IDLE) &&
                   (cmd == KIND_SET_PIXEL_AT || cmd == KIND_READ_PIXEL);
  assign ag_x    = use_pos ? pos_x : cursor.x;
  assign ag_y    = use_pos ? pos_y : cursor.y;

  fbw_addr_gen #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_addr_gen (
    .surface_width  (surface_width),
    .surface_height (surface_height),
    .x              (ag_x),
    .y              (ag_y),
    .in_bounds      (ag_inside),
    .addr           (ag_addr)
  );

  assign cursor_next = fbw_cursor_step(cursor, window);

  // Packed index count, saturated to what one byte holds
  assign per_byte  = fbw_per_byte(index_bits);
  assign count_sat = (valid_pixels > per_byte) ? per_byte : valid_pixels;

  // Palette read: first index at accept, later ones from the shift register
  assign pal_idx      = (state == ST_PACK) ? (pk_shift & pk_mask)
                                           : (packed_byte & fbw_index_mask(index_bits));
  assign pal_in_range = 32'(pal_idx) < PALETTE_DEPTH;
  assign pal_raddr    = pal_in_range ? pal_idx[PW-1:0] : '0;
  assign pal_we       = accept && (cmd == KIND_LOAD_PALETTE) &&
                        (32'(palette_index) < PALETTE_DEPTH);

  fbw_palette_ram #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (PW)
  ) u_palette_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (palette_index[PW-1:0]),
    .wdata (pixel_value),
    .raddr (pal_raddr),
    .rdata (pal_q)
  );

  assign colour = pal_zero ? 16'h0000 : pal_q;

  // Frame store write: clearing pass, direct writes, cursor writes
  always_comb begin
    fr_we    = 1'b0;
    fr_waddr = ag_addr;
    fr_wdata = pixel_value;
    case (state)
      ST_CLEAR: begin
        fr_we    = 1'b1;
        fr_waddr = clear_cnt;
        fr_wdata = 16'h0000;
      end
      ST_IDLE: begin
        fr_we = accept && ag_inside &&
                (cmd == KIND_WRITE_PIXEL || cmd == KIND_SET_PIXEL_AT);
      end
      ST_PACK: begin
        fr_we    = ag_inside;
        fr_wdata = colour;
      end
      default: begin
        fr_we = 1'b0;
      end
    endcase
  end

  fbw_frame_ram #(
    .DEPTH (FRAME_DEPTH),
    .AW    (AW)
  ) u_frame_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (ag_addr),
    .rdata (fr_q)
  );

  // Sequencer, window, cursor, configuration and result register
  always_ff @(posedge clk) begin
    pal_zero   <= !pal_in_range;
    read_valid <= 1'b0;
    if (rst) begin
      state          <= ST_CLEAR;
      clear_cnt      <= '0;
      surface_width  <= CFG_RESET_SIZE;
      surface_height <= CFG_RESET_SIZE;
      window         <= '0;
      cursor         <= '0;
      read_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SURFACE_WIDTH) begin
          surface_width <= cfg_data;
        end else begin
          surface_height <= cfg_data;
        end
      end
      case (state)
        ST_CLEAR: begin
          clear_cnt <= clear_cnt + AW'(1);
          if (clear_cnt == CLEAR_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            case (cmd)
              KIND_SET_WINDOW: begin
                window.left   <= win_left;
                window.top    <= win_top;
                window.right  <= win_right;
                window.bottom <= win_bottom;
                cursor.x      <= win_left;
                cursor.y      <= win_top;
              end
              KIND_WRITE_PIXEL: begin
                cursor <= cursor_next;
              end
              KIND_WRITE_PACKED: begin
                pk_shift <= packed_byte >> index_bits;
                pk_mask  <= fbw_index_mask(index_bits);
                pk_bits  <= index_bits;
                pk_left  <= count_sat;
                if (count_sat != 4'd0) begin
                  state <= ST_PACK;
                end
              end
              KIND_READ_PIXEL: begin
                rd_inside <= ag_inside;
                state     <= ST_READ;
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          read_data  <= rd_inside ? fr_q : 16'h0000;
          read_valid <= 1'b1;
          state      <= ST_IDLE;
        end
        ST_PACK: begin
          cursor   <= cursor_next;
          pk_left  <= pk_left - 4'd1;
          pk_shift <= pk_shift >> pk_bits;
          if (pk_left == 4'd1) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* sim/framebuffer_window_pixel_writer_tb.sv */
// Self-checking testbench: directed and random command streams against a frame store model.
module framebuffer_window_pixel_writer_tb;
  import fbw_pkg::*;

  localparam int SURF_MAX       = 256;
  localparam int PAL_DEPTH      = 256;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE_CYCLES  = 16;

  // Kind codes the block has no use for
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;

  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  win_left;
    logic [7:0]  win_top;
    logic [7:0]  win_right;
    logic [7:0]  win_bottom;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [15:0] pixel_value;
    logic [7:0]  packed_byte;
    logic [3:0]  index_bits;
    logic [3:0]  valid_pixels;
    logic [7:0]  palette_index;
  } cmd_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  logic [2:0]       kind;
  logic [7:0]       win_left;
  logic [7:0]       win_top;
  logic [7:0]       win_right;
  logic [7:0]       win_bottom;
  logic [7:0]       pos_x;
  logic [7:0]       pos_y;
  logic [15:0]      pixel_value;
  logic [7:0]       packed_byte;
  logic [3:0]       index_bits;
  logic [3:0]       valid_pixels;
  logic [7:0]       palette_index;
  logic [15:0]      read_data;
  logic             read_valid;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // Model of the block: frame image, palette, surface size, window and cursor
  logic [15:0] frame_img [0:SURF_MAX*SURF_MAX-1];
  logic [15:0] pal_img [0:PAL_DEPTH-1];
  bit          pal_set [0:PAL_DEPTH-1];
  logic [8:0]  surf_w;
  logic [8:0]  surf_h;
  logic [7:0]  win_l, win_t, win_r, win_b;
  logic [7:0]  cur_x, cur_y;
  logic [15:0] read_expect_q [$];

  logic [15:0] read_want;
  int          errors;
  int          cmd_count;
  int          packed_pixels;
  int          reads_checked;
  int          surf_settings;
  int          idle_pct;
  int          stall_cycles;

  framebuffer_window_pixel_writer DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .win_left      (win_left),
    .win_top       (win_top),
    .win_right     (win_right),
    .win_bottom    (win_bottom),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pixel_value   (pixel_value),
    .packed_byte   (packed_byte),
    .index_bits    (index_bits),
    .valid_pixels  (valid_pixels),
    .palette_index (palette_index),
    .read_data     (read_data),
    .read_valid    (read_valid),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 12-unit clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Width after saturation to the store size
  function automatic int eff_w();
    return (surf_w > 9'(SURF_MAX)) ? SURF_MAX : int'(surf_w);
  endfunction

  function automatic bit on_surface(input logic [7:0] x, input logic [7:0] y);
    int h;
    h = (surf_h > 9'(SURF_MAX)) ? SURF_MAX : int'(surf_h);
    return int'(x) < eff_w() && int'(y) < h;
  endfunction

  function automatic void plot(input logic [7:0] x, input logic [7:0] y,
                               input logic [15:0] v);
    if (on_surface(x, y)) begin
      frame_img[int'(y) * eff_w() + int'(x)] = v;
    end
  endfunction

  // Raster step inside the window, 9-bit compare so 255 steps past the edge
  function automatic void step_cursor();
    logic [8:0] nx;
    logic [8:0] ny;
    nx = {1'b0, cur_x} + 9'd1;
    ny = {1'b0, cur_y};
    if (nx > {1'b0, win_r}) begin
      nx = {1'b0, win_l};
      ny = ny + 9'd1;
    end
    if (ny > {1'b0, win_b}) begin
      ny = {1'b0, win_t};
    end
    cur_x = nx[7:0];
    cur_y = ny[7:0];
  endfunction

  // Indices written by a packed transaction; zero for a bad index width
  function automatic int packed_count(input cmd_t c);
    int per;
    if (c.index_bits != 4'd1 && c.index_bits != 4'd2 &&
        c.index_bits != 4'd4 && c.index_bits != 4'd8) begin
      return 0;
    end
    per = 8 / int'(c.index_bits);
    return (int'(c.valid_pixels) > per) ? per : int'(c.valid_pixels);
  endfunction

  function automatic int packed_index(input cmd_t c, input int i);
    int ib;
    ib = int'(c.index_bits);
    return (int'(c.packed_byte) >> (i * ib)) & ((1 << ib) - 1);
  endfunction

  // Apply one accepted transaction to the model, queue any read-back
  function automatic void update_frame_model(input cmd_t c);
    case (c.kind)
      KIND_SET_WINDOW: begin
        win_l = c.win_left;
        win_t = c.win_top;
        win_r = c.win_right;
        win_b = c.win_bottom;
        cur_x = c.win_left;
        cur_y = c.win_top;
      end
      KIND_WRITE_PIXEL: begin
        plot(cur_x, cur_y, c.pixel_value);
        step_cursor();
      end
      KIND_WRITE_PACKED: begin
        for (int i = 0; i < packed_count(c); i++) begin
          plot(cur_x, cur_y, pal_img[packed_index(c, i)]);
          step_cursor();
          packed_pixels++;
        end
      end
      KIND_SET_PIXEL_AT: plot(c.pos_x, c.pos_y, c.pixel_value);
      KIND_LOAD_PALETTE: begin
        pal_img[c.palette_index] = c.pixel_value;
        pal_set[c.palette_index] = 1'b1;
      end
      KIND_READ_PIXEL: begin
        read_expect_q.push_back(on_surface(c.pos_x, c.pos_y) ?
                                frame_img[int'(c.pos_y) * eff_w() + int'(c.pos_x)] :
                                16'h0000);
      end
      default: ;
    endcase
  endfunction

  // Transaction of a given kind with every other field random
  function automatic cmd_t base_cmd(input logic [2:0] k);
    cmd_t c;
    c.kind          = k;
    c.win_left      = 8'($urandom);
    c.win_top       = 8'($urandom);
    c.win_right     = 8'($urandom);
    c.win_bottom    = 8'($urandom);
    c.pos_x         = 8'($urandom);
    c.pos_y         = 8'($urandom);
    c.pixel_value   = 16'($urandom);
    c.packed_byte   = 8'($urandom);
    c.index_bits    = 4'($urandom);
    c.valid_pixels  = 4'($urandom);
    c.palette_index = 8'($urandom);
    return c;
  endfunction

  function automatic cmd_t win_cmd(input logic [7:0] l, input logic [7:0] t,
                                   input logic [7:0] r, input logic [7:0] b);
    cmd_t c;
    c = base_cmd(KIND_SET_WINDOW);
    c.win_left   = l;
    c.win_top    = t;
    c.win_right  = r;
    c.win_bottom = b;
    return c;
  endfunction

  function automatic cmd_t pix_cmd(input logic [2:0] k, input logic [7:0] x,
                                   input logic [7:0] y, input logic [15:0] v);
    cmd_t c;
    c = base_cmd(k);
    c.pos_x       = x;
    c.pos_y       = y;
    c.pixel_value = v;
    return c;
  endfunction

  function automatic cmd_t pal_cmd(input logic [7:0] idx, input logic [15:0] v);
    cmd_t c;
    c = base_cmd(KIND_LOAD_PALETTE);
    c.palette_index = idx;
    c.pixel_value   = v;
    return c;
  endfunction

  function automatic cmd_t pk_cmd(input logic [7:0] b, input logic [3:0] ib,
                                  input logic [3:0] np);
    cmd_t c;
    c = base_cmd(KIND_WRITE_PACKED);
    c.packed_byte  = b;
    c.index_bits   = ib;
    c.valid_pixels = np;
    return c;
  endfunction

  // Random transaction, weighted toward small windows near the surface
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int sel;
    int lim;
    sel = $urandom_range(0, 99);
    lim = (eff_w() + 2 > 255) ? 255 : eff_w() + 2;
    if (sel < 10) begin
      c = base_cmd(KIND_SET_WINDOW);
      if ($urandom_range(0, 3) != 0) begin
        c.win_left   = 8'($urandom_range(0, lim));
        c.win_top    = 8'($urandom_range(0, lim));
        c.win_right  = 8'(int'(c.win_left) + $urandom_range(0, 7));
        c.win_bottom = 8'(int'(c.win_top) + $urandom_range(0, 7));
      end
    end else if (sel < 35) begin
      c = base_cmd(KIND_WRITE_PIXEL);
    end else if (sel < 50) begin
      c = base_cmd(KIND_WRITE_PACKED);
      if ($urandom_range(0, 6) != 0) begin
        c.index_bits = 4'(1 << $urandom_range(0, 3));
        if ($urandom_range(0, 4) != 0) begin
          c.valid_pixels = 4'($urandom_range(1, 8 / int'(c.index_bits)));
        end
      end
    end else if (sel < 60) begin
      c = base_cmd(KIND_SET_PIXEL_AT);
      if ($urandom_range(0, 2) != 0) begin
        c.pos_x = 8'(int'(win_l) + $urandom_range(0, 9));
        c.pos_y = 8'(int'(win_t) + $urandom_range(0, 9));
      end
    end else if (sel < 68) begin
      c = base_cmd(KIND_LOAD_PALETTE);
    end else if (sel < 95) begin
      c = base_cmd(KIND_READ_PIXEL);
      if ($urandom_range(0, 9) < 7) begin
        c.pos_x = 8'(int'(win_l) + $urandom_range(0, 9));
        c.pos_y = 8'(int'(win_t) + $urandom_range(0, 9));
      end
    end else begin
      c = base_cmd($urandom_range(0, 1) ? KIND_SPARE_7 : KIND_SPARE_6);
    end
    return c;
  endfunction

  // Present one transaction and hold it until the block takes it
  task automatic send_cmd(input cmd_t c);
    kind          <= c.kind;
    win_left      <= c.win_left;
    win_top       <= c.win_top;
    win_right     <= c.win_right;
    win_bottom    <= c.win_bottom;
    pos_x         <= c.pos_x;
    pos_y         <= c.pos_y;
    pixel_value   <= c.pixel_value;
    packed_byte   <= c.packed_byte;
    index_bits    <= c.index_bits;
    valid_pixels  <= c.valid_pixels;
    palette_index <= c.palette_index;
    start         <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    update_frame_model(c);
    cmd_count++;
  endtask

  // Stop sending until all read-backs are in and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (read_expect_q.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  // Send with palette entries filled first, then idle cycle by cycle
  task automatic issue(input cmd_t c);
    int idx;
    if (c.kind == KIND_WRITE_PACKED) begin
      for (int i = 0; i < packed_count(c); i++) begin
        idx = packed_index(c, i);
        if (!pal_set[idx]) begin
          send_cmd(pal_cmd(8'(idx), 16'($urandom)));
        end
      end
    end
    send_cmd(c);
    if ($urandom_range(0, 199) == 0) begin
      drain();
    end else begin
      while ($urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // Both registers rewritten while the block is idle
  task automatic set_surface(input logic [8:0] w, input logic [8:0] h);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SURFACE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_SURFACE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    surf_w = w;
    surf_h = h;
    surf_settings++;
  endtask

  // Store is clear after reset; corner pixel writes and reads back
  task automatic test_reset_and_corner();
    issue(pix_cmd(KIND_READ_PIXEL, 8'd0, 8'd0, 16'h0000));
    issue(pix_cmd(KIND_SET_PIXEL_AT, 8'd255, 8'd255, 16'hFFFF));
    issue(pix_cmd(KIND_READ_PIXEL, 8'd255, 8'd255, 16'h0000));
  endtask

  // Window at the far corner: cursor steps past 255 and wraps to the top
  task automatic test_window_wrap();
    issue(win_cmd(8'd254, 8'd254, 8'd255, 8'd255));
    issue(pix_cmd(KIND_WRITE_PIXEL, 8'd0, 8'd0, 16'h0001));
    issue(pix_cmd(KIND_WRITE_PIXEL, 8'd0, 8'd0, 16'hFFFF));
    issue(pix_cmd(KIND_WRITE_PIXEL, 8'd0, 8'd0, 16'h8000));
    issue(pix_cmd(KIND_WRITE_PIXEL, 8'd0, 8'd0, 16'h7FFE));
    issue(pix_cmd(KIND_WRITE_PIXEL, 8'd0, 8'd0, 16'h0000));
    issue(pix_cmd(KIND_READ_PIXEL, 8'd254, 8'd254, 16'h0000));
  endtask

  // Every index width, saturated count, bad width and zero count
  task automatic test_packed_expand();
    issue(pal_cmd(8'd0, 16'h1234));
    issue(pal_cmd(8'd1, 16'hFFFF));
    issue(pal_cmd(8'd3, 16'h0000));
    issue(pal_cmd(8'd255, 16'hA5A5));
    issue(win_cmd(8'd0, 8'd0, 8'd3, 8'd3));
    issue(pk_cmd(8'h02, 4'd1, 4'd2));
    issue(pk_cmd(8'h34, 4'd2, 4'd15));
    issue(pk_cmd(8'h10, 4'd4, 4'd2));
    issue(pk_cmd(8'hFF, 4'd8, 4'd1));
    issue(pk_cmd(8'hFF, 4'd5, 4'd8));
    issue(pk_cmd(8'hFF, 4'd2, 4'd0));
    issue(pix_cmd(KIND_READ_PIXEL, 8'd1, 8'd2, 16'h0000));
  endtask

  // Kinds with no meaning leave everything alone
  task automatic test_spare_kinds();
    issue(base_cmd(KIND_SPARE_6));
    issue(base_cmd(KIND_SPARE_7));
  endtask

  // Zero width and zero height put every position off the surface
  task automatic test_surface_limits();
    set_surface(9'd0, 9'd256);
    issue(pix_cmd(KIND_SET_PIXEL_AT, 8'd0, 8'd0, 16'h5555));
    issue(pix_cmd(KIND_READ_PIXEL, 8'd0, 8'd0, 16'h0000));
    set_surface(9'd256, 9'd0);
    issue(pix_cmd(KIND_READ_PIXEL, 8'd0, 8'd0, 16'h0000));
  endtask

  task automatic test_random_phase(input int n, input logic [8:0] w,
                                   input logic [8:0] h, input int pct);
    cmd_t c;
    int sent;
    set_surface(w, h);
    idle_pct = pct;
    sent = 0;
    while (sent < n) begin
      c = rand_cmd();
      issue(c);
      if (c.kind != KIND_SPARE_6 && c.kind != KIND_SPARE_7) begin
        sent++;
      end
    end
  endtask

  // Result checker: each strobe against the oldest pending read
  always @(posedge clk) begin
    if (!rst && read_valid) begin
      if (read_expect_q.size() == 0) begin
        $display("%0t: unexpected read_data, expected none, actual %h", $time, read_data);
        errors++;
      end else begin
        read_want = read_expect_q.pop_front();
        reads_checked++;
        if (read_data !== read_want) begin
          $display("%0t: read_data expected %h actual %h", $time, read_want, read_data);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles with no transaction either way
  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || read_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("framebuffer_window_pixel_writer: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst           <= 1'b1;
    start         <= 1'b0;
    kind          <= '0;
    win_left      <= '0;
    win_top       <= '0;
    win_right     <= '0;
    win_bottom    <= '0;
    pos_x         <= '0;
    pos_y         <= '0;
    pixel_value   <= '0;
    packed_byte   <= '0;
    index_bits    <= '0;
    valid_pixels  <= '0;
    palette_index <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_SURFACE_WIDTH;
    cfg_data      <= '0;
    for (int i = 0; i < SURF_MAX * SURF_MAX; i++) frame_img[i] = 16'h0000;
    for (int i = 0; i < PAL_DEPTH; i++) pal_set[i] = 1'b0;
    surf_w = CFG_RESET_SIZE;
    surf_h = CFG_RESET_SIZE;
    win_l = '0; win_t = '0; win_r = '0; win_b = '0;
    cur_x = '0; cur_y = '0;
    errors = 0; cmd_count = 0; packed_pixels = 0;
    reads_checked = 0; surf_settings = 0;
    idle_pct = 32;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_and_corner();
    test_window_wrap();
    test_packed_expand();
    test_spare_kinds();
    test_surface_limits();

    // Sender idles 32%, then 49%, then never
    test_random_phase(350, 9'd256, 9'd256, 32);
    test_random_phase(300, 9'd16, 9'd12, 32);
    test_random_phase(300, 9'd511, 9'd511, 49);
    test_random_phase(150, 9'd1, 9'd1, 49);
    test_random_phase(350, 9'd100, 9'd37, 0);
    test_random_phase(200, 9'd257, 9'd3, 0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (read_expect_q.size() != 0) begin
      $display("%0t: %0d read-backs expected, none arrived", $time, read_expect_q.size());
      errors++;
    end
    $display("run: %0d commands sent, %0d palette pixels expanded, %0d read-backs checked",
             cmd_count, packed_pixels, reads_checked);
    $display("run: %0d surface sizes, window wrap, packed widths and off-surface writes",
             surf_settings);
    if (errors == 0) begin
      $display("framebuffer_window_pixel_writer: match");
    end else begin
      $display("framebuffer_window_pixel_writer: mismatch");
    end
    $finish;
  end

endmodule
